// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expression does not hold");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle implication");

`endif

// ----- hw/rtl/wslt_pkg.sv -----
package wslt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int MAC_W       = 48;
   localparam int MCAST_BIT   = 40;

   localparam logic [8:0] CAPACITY_RESET  = 9'd200;
   localparam logic [1:0] FRAME_TYPE_DATA = 2'd2;

   typedef enum logic [1:0] {
      MODE_OBSERVE = 2'd0,
      MODE_READ    = 2'd1,
      MODE_CLEAR   = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ST_NOT_DATA  = 4'd0,
      ST_BAD_DIR   = 4'd1,
      ST_MULTICAST = 4'd2,
      ST_UPDATED   = 4'd3,
      ST_INSERTED  = 4'd4,
      ST_FULL      = 4'd5,
      ST_READ_OK   = 4'd6,
      ST_READ_OOR  = 4'd7,
      ST_CLEARED   = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      OP_REJECT,
      OP_SCAN,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_RDATA,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [MAC_W-1:0] station;
      logic [MAC_W-1:0] access_point;
      logic [7:0]       rssi;
      logic [7:0]       channel;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic rd_req;
      logic clear_count;
      logic update;
      logic insert;
      logic full;
      logic res_read;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   hit;
      logic   scan_done;
      logic   room;
      logic   out_busy;
   } dp_stat_type;

endpackage

// ----- hw/rtl/wslt_dpath.sv -----
module wslt_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  wslt_pkg::cmd_type              cmd,
   output wslt_pkg::dp_stat_type          stat,
   input  logic                           csr_wr_en,
   input  logic [8:0]                     csr_wr_data,
   input  logic [1:0]                     req_mode,
   input  logic                           req_is_data_packet,
   input  logic [1:0]                     req_frame_type,
   input  logic                           req_to_ds,
   input  logic                           req_from_ds,
   input  logic [47:0]                    req_addr1,
   input  logic [47:0]                    req_addr2,
   input  logic signed [7:0]              req_rssi,
   input  logic [7:0]                     req_channel,
   input  logic [7:0]                     req_read_index,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [3:0]                     rsp_status,
   output logic [7:0]                     rsp_entry_index,
   output logic [8:0]                     rsp_entry_count,
   output logic [47:0]                    rsp_out_station,
   output logic [47:0]                    rsp_out_access_point,
   output logic signed [7:0]              rsp_out_rssi,
   output logic [7:0]                     rsp_out_channel
);
   import wslt_pkg::*;

   // captured request
   logic [MAC_W-1:0] sta_ff, sta_in;
   logic [MAC_W-1:0] ap_ff, ap_in;
   logic [7:0]       rssi_ff;
   logic [7:0]       chan_ff;
   logic [IDX_W-1:0] ridx_ff;
   op_type           op_ff, op_in;
   status_type       req_status;

   // pending result
   status_type       res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_index_ff, res_index_in;
   logic             res_show_ff, res_show_in;

   // table and search
   entry_type        entry_mem_ff [TABLE_DEPTH];
   entry_type        rd_data_ff;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [8:0]       cap_ff, cap_in;

   logic             more;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_status_ff;
   logic [7:0]       rsp_index_ff;
   logic [8:0]       rsp_count_ff;
   entry_type        rsp_entry_ff;

   assign more    = scan_idx_ff < count_ff;
   assign rd_en   = (cmd.scan_step && more) || cmd.rd_req;
   assign rd_addr = cmd.rd_req ? ridx_ff : scan_idx_ff[IDX_W-1:0];
   assign wr_en   = cmd.update || cmd.insert;
   assign wr_addr = cmd.update ? cmp_idx_ff : count_ff[IDX_W-1:0];
   assign wr_data = '{station: sta_ff, access_point: ap_ff, rssi: rssi_ff, channel: chan_ff};

   assign stat.op        = op_ff;
   assign stat.hit       = cmp_vld_ff && (rd_data_ff.station == sta_ff);
   assign stat.scan_done = !cmp_vld_ff && !more;
   assign stat.room      = (count_ff < cap_ff) && (count_ff < CNT_W'(TABLE_DEPTH));
   assign stat.out_busy  = rsp_valid_ff && rsp_stall;

   // request classification at capture
   always_comb begin
      sta_in     = req_to_ds ? req_addr2 : req_addr1;
      ap_in      = req_to_ds ? req_addr1 : req_addr2;
      op_in      = OP_REJECT;
      req_status = ST_NOT_DATA;
      case (req_mode)
         MODE_OBSERVE: begin
            if (!req_is_data_packet || req_frame_type != FRAME_TYPE_DATA) begin
               req_status = ST_NOT_DATA;
            end else if (req_to_ds == req_from_ds) begin
               req_status = ST_BAD_DIR;
            end else if (sta_in[MCAST_BIT]) begin
               req_status = ST_MULTICAST;
            end else begin
               op_in = OP_SCAN;
            end
         end
         MODE_READ: begin
            if ({1'b0, req_read_index} < count_ff) begin
               op_in = OP_READ;
            end else begin
               req_status = ST_READ_OOR;
            end
         end
         MODE_CLEAR: begin
            op_in      = OP_CLEAR;
            req_status = ST_CLEARED;
         end
         default: begin
            req_status = ST_NOT_DATA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sta_ff  <= sta_in;
         ap_ff   <= ap_in;
         rssi_ff <= $unsigned(req_rssi);
         chan_ff <= req_channel;
         ridx_ff <= req_read_index;
         op_ff   <= op_in;
      end
   end

   // result bookkeeping
   always_comb begin
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_show_in   = res_show_ff;
      if (cmd.capture) begin
         res_status_in = req_status;
         res_index_in  = '0;
         res_show_in   = 1'b0;
      end else if (cmd.update) begin
         res_status_in = ST_UPDATED;
         res_index_in  = cmp_idx_ff;
      end else if (cmd.insert) begin
         res_status_in = ST_INSERTED;
         res_index_in  = count_ff[IDX_W-1:0];
      end else if (cmd.full) begin
         res_status_in = ST_FULL;
      end else if (cmd.res_read) begin
         res_status_in = ST_READ_OK;
         res_index_in  = ridx_ff;
         res_show_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_show_ff   <= res_show_in;
   end

   // search pointer and count
   always_comb begin
      scan_idx_in = scan_idx_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      count_in    = count_ff;
      cap_in      = cap_ff;
      if (cmd.capture) begin
         scan_idx_in = '0;
         cmp_vld_in  = 1'b0;
      end else if (cmd.scan_step) begin
         cmp_vld_in = more;
         if (more) begin
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
         end
      end
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.clear_count) begin
         count_in = '0;
      end
      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
         count_ff   <= '0;
         cap_ff     <= CAPACITY_RESET;
      end else begin
         cmp_vld_ff <= cmp_vld_in;
         count_ff   <= count_in;
         cap_ff     <= cap_in;
      end
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_count_ff  <= count_ff;
         rsp_entry_ff  <= res_show_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_entry_index      = rsp_index_ff;
   assign rsp_entry_count      = rsp_count_ff;
   assign rsp_out_station      = rsp_entry_ff.station;
   assign rsp_out_access_point = rsp_entry_ff.access_point;
   assign rsp_out_rssi         = $signed(rsp_entry_ff.rssi);
   assign rsp_out_channel      = rsp_entry_ff.channel;

endmodule

// ----- hw/rtl/wslt_ctrl.sv -----
module wslt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wslt_pkg::dp_stat_type stat,
   output wslt_pkg::cmd_type     cmd
);
   import wslt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (stat.op)
               OP_SCAN: state_in = S_SCAN;
               OP_READ: state_in = S_RDATA;
               default: state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            if (stat.hit || stat.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_RDATA: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECIDE: begin
            case (stat.op)
               OP_CLEAR: cmd.clear_count = 1'b1;
               OP_READ:  cmd.rd_req      = 1'b1;
               default:  cmd.clear_count = 1'b0;
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit) begin
               cmd.update = 1'b1;
            end else if (stat.scan_done) begin
               // miss: append while there is room
               cmd.insert = stat.room;
               cmd.full   = !stat.room;
            end
         end
         S_RDATA: begin
            cmd.res_read = 1'b1;
         end
         S_DONE: begin
            cmd.load_rsp = !stat.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/wlan_station_learning_table.sv -----
// Station learning table: one request per observed frame, read or clear. An observe
// request searches the stored station addresses one entry per cycle through the single
// read port of the entry memory. A miss searches every stored entry and a hit stops the
// search at the matching entry; an in-range read passes through the read data state, and
// a rejected frame, a clear or an unused mode 3 goes straight to the result. Requests are
// handled one at a time, and a new request is taken while the previous result still waits
// in the output register; its own result then waits for that register to drain. There is
// no clearing pass after reset: only entries below the count are ever searched or read.
`include "assert_macros.svh"

module wlan_station_learning_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [8:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic               req_is_data_packet,
   input  logic [1:0]         req_frame_type,
   input  logic               req_to_ds,
   input  logic               req_from_ds,
   input  logic [47:0]        req_addr1,
   input  logic [47:0]        req_addr2,
   input  logic signed [7:0]  req_rssi,
   input  logic [7:0]         req_channel,
   input  logic [7:0]         req_read_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_status,
   output logic [7:0]         rsp_entry_index,
   output logic [8:0]         rsp_entry_count,
   output logic [47:0]        rsp_out_station,
   output logic [47:0]        rsp_out_access_point,
   output logic signed [7:0]  rsp_out_rssi,
   output logic [7:0]         rsp_out_channel
);
   import wslt_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;
   logic        req_ready;
   logic [8:0]  rsp_index_wide;
   logic        rsp_read_ok;
   logic        rsp_inserted;

   assign req_stall = !req_ready || reset;

   assign rsp_index_wide = {1'b0, rsp_entry_index};
   assign rsp_read_ok    = rsp_valid && rsp_status == ST_READ_OK;
   assign rsp_inserted   = rsp_valid && rsp_status == ST_INSERTED;

   wslt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wslt_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_mode             (req_mode),
      .req_is_data_packet   (req_is_data_packet),
      .req_frame_type       (req_frame_type),
      .req_to_ds            (req_to_ds),
      .req_from_ds          (req_from_ds),
      .req_addr1            (req_addr1),
      .req_addr2            (req_addr2),
      .req_rssi             (req_rssi),
      .req_channel          (req_channel),
      .req_read_index       (req_read_index),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_entry_index      (rsp_entry_index),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_out_station      (rsp_out_station),
      .rsp_out_access_point (rsp_out_access_point),
      .rsp_out_rssi         (rsp_out_rssi),
      .rsp_out_channel      (rsp_out_channel)
   );

   // one request at a time
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMPLIES(a_count_bound, clock, reset, rsp_valid, rsp_entry_count <= 9'(TABLE_DEPTH))
   `ASSERT_IMPLIES(a_read_in_range, clock, reset, rsp_read_ok, rsp_index_wide < rsp_entry_count)
   `ASSERT_IMPLIES(a_insert_last, clock, reset, rsp_inserted, rsp_index_wide + 9'd1 == rsp_entry_count)

endmodule

// ----- tb/wlan_station_learning_table_test.sv -----
`timescale 1ns / 1ps

module wlan_station_learning_table_test;
   import wslt_pkg::*;

   localparam logic [1:0]  MODE_UNUSED     = 2'd3;
   localparam int          QUIET_LIMIT     = 4000;
   localparam int          MAX_WAIT        = 17;
   localparam int          REQUEST_TARGET  = 1750;
   localparam int          DRAIN_CYCLES    = 300;
   localparam int          REPORT_LIMIT    = 10;
   localparam logic [47:0] MAC_ONES        = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] MAC_TOP_UNICAST = 48'hFEFF_FFFF_FFFF;
   localparam logic [47:0] MAC_GROUP_ONLY  = 48'h0100_0000_0000;

   typedef struct {
      logic [1:0]        mode;
      logic              is_data;
      logic [1:0]        ftype;
      logic              to_ds;
      logic              from_ds;
      logic [47:0]       addr1;
      logic [47:0]       addr2;
      logic signed [7:0] rssi;
      logic [7:0]        channel;
      logic [7:0]        read_index;
      bit                drain_first;
   } req_item_type;

   typedef struct packed {
      status_type        status;
      logic [7:0]        index;
      logic [8:0]        count;
      logic [47:0]       station;
      logic [47:0]       access_point;
      logic signed [7:0] rssi;
      logic [7:0]        channel;
   } learn_result_type;

   logic              clock                = 1'b0;
   logic              reset                = 1'b1;
   logic              csr_wr_en            = 1'b0;
   logic [8:0]        csr_wr_data          = 9'd0;
   logic              req_valid            = 1'b0;
   logic              req_stall;
   logic [1:0]        req_mode             = 2'd0;
   logic              req_is_data_packet   = 1'b0;
   logic [1:0]        req_frame_type       = 2'd0;
   logic              req_to_ds            = 1'b0;
   logic              req_from_ds          = 1'b0;
   logic [47:0]       req_addr1            = 48'd0;
   logic [47:0]       req_addr2            = 48'd0;
   logic signed [7:0] req_rssi             = 8'sd0;
   logic [7:0]        req_channel          = 8'd0;
   logic [7:0]        req_read_index       = 8'd0;
   logic              rsp_valid;
   logic              rsp_stall            = 1'b0;
   logic [3:0]        rsp_status;
   logic [7:0]        rsp_entry_index;
   logic [8:0]        rsp_entry_count;
   logic [47:0]       rsp_out_station;
   logic [47:0]       rsp_out_access_point;
   logic signed [7:0] rsp_out_rssi;
   logic [7:0]        rsp_out_channel;

   req_item_type     request_queue[$];
   learn_result_type pending_results[$];

   // mirror of the station table
   logic [47:0]       learned_station [TABLE_DEPTH];
   logic [47:0]       learned_ap      [TABLE_DEPTH];
   logic signed [7:0] learned_rssi    [TABLE_DEPTH];
   logic [7:0]        learned_channel [TABLE_DEPTH];
   int                learned_count   = 0;
   int                capacity_shadow = int'(CAPACITY_RESET);

   int failures        = 0;
   int requests_queued = 0;
   int gap_left        = 0;
   int rsp_hold        = 0;
   int quiet_cycles    = 0;
   bit send_idle_on    = 1'b1;
   bit recv_idle_on    = 1'b1;

   wlan_station_learning_table u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_is_data_packet   (req_is_data_packet),
      .req_frame_type       (req_frame_type),
      .req_to_ds            (req_to_ds),
      .req_from_ds          (req_from_ds),
      .req_addr1            (req_addr1),
      .req_addr2            (req_addr2),
      .req_rssi             (req_rssi),
      .req_channel          (req_channel),
      .req_read_index       (req_read_index),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_entry_index      (rsp_entry_index),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_out_station      (rsp_out_station),
      .rsp_out_access_point (rsp_out_access_point),
      .rsp_out_rssi         (rsp_out_rssi),
      .rsp_out_channel      (rsp_out_channel)
   );

   always #5 clock = ~clock;

   function automatic learn_result_type learn_step(
      input logic [1:0]        mode,
      input logic              is_data,
      input logic [1:0]        ftype,
      input logic              to_ds,
      input logic              from_ds,
      input logic [47:0]       addr1,
      input logic [47:0]       addr2,
      input logic signed [7:0] rssi,
      input logic [7:0]        channel,
      input logic [7:0]        read_index
   );
      learn_result_type res;
      logic [47:0]      sta;
      logic [47:0]      ap;
      int               limit;
      int               slot;
      res = '0;
      res.status = ST_NOT_DATA;
      if (mode == MODE_OBSERVE) begin
         sta = to_ds ? addr2 : addr1;
         ap = to_ds ? addr1 : addr2;
         limit = (capacity_shadow < TABLE_DEPTH) ? capacity_shadow : TABLE_DEPTH;
         slot = -1;
         for (int i = 0; i < learned_count; i++)
            if (slot < 0 && learned_station[i] == sta) slot = i;
         if (!is_data || ftype != FRAME_TYPE_DATA) begin
            res.status = ST_NOT_DATA;
         end else if (to_ds == from_ds) begin
            res.status = ST_BAD_DIR;
         end else if (sta[MCAST_BIT]) begin
            res.status = ST_MULTICAST;
         end else if (slot >= 0) begin
            learned_ap[slot] = ap;
            learned_rssi[slot] = rssi;
            learned_channel[slot] = channel;
            res.status = ST_UPDATED;
            res.index = 8'(slot);
         end else if (learned_count < limit) begin
            learned_station[learned_count] = sta;
            learned_ap[learned_count] = ap;
            learned_rssi[learned_count] = rssi;
            learned_channel[learned_count] = channel;
            res.status = ST_INSERTED;
            res.index = 8'(learned_count);
            learned_count++;
         end else begin
            res.status = ST_FULL;
         end
      end else if (mode == MODE_READ) begin
         if (int'(read_index) < learned_count) begin
            res.status = ST_READ_OK;
            res.index = read_index;
            res.station = learned_station[read_index];
            res.access_point = learned_ap[read_index];
            res.rssi = learned_rssi[read_index];
            res.channel = learned_channel[read_index];
         end else begin
            res.status = ST_READ_OOR;
         end
      end else if (mode == MODE_CLEAR) begin
         learned_count = 0;
         res.status = ST_CLEARED;
      end
      res.count = 9'(learned_count);
      return res;
   endfunction

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (got !== want)
         log_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
   endtask

   // driver: presents queued requests, holds while stalled
   always @(posedge clock) begin : driver
      req_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (request_queue.size() > 0 &&
                      !(request_queue[0].drain_first &&
                        (req_valid || pending_results.size() > 0))) begin
            nxt = request_queue.pop_front();
            req_valid <= 1'b1;
            req_mode <= nxt.mode;
            req_is_data_packet <= nxt.is_data;
            req_frame_type <= nxt.ftype;
            req_to_ds <= nxt.to_ds;
            req_from_ds <= nxt.from_ds;
            req_addr1 <= nxt.addr1;
            req_addr2 <= nxt.addr2;
            req_rssi <= nxt.rssi;
            req_channel <= nxt.channel;
            req_read_index <= nxt.read_index;
            gap_left <= send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: checks results against the oldest prediction, then records new requests
   always @(posedge clock) begin : monitor
      learn_result_type want;
      int               hold_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else begin
         hold_next = rsp_hold;
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               log_failure($sformatf("result with no request pending, status %0d",
                                     rsp_status));
            end else begin
               want = pending_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("entry_index", want.index, rsp_entry_index);
               check_field("entry_count", want.count, rsp_entry_count);
               check_field("out_station", want.station, rsp_out_station);
               check_field("out_access_point", want.access_point, rsp_out_access_point);
               check_field("out_rssi", want.rssi, rsp_out_rssi);
               check_field("out_channel", want.channel, rsp_out_channel);
            end
            hold_next = recv_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (req_valid && !req_stall)
            pending_results.push_back(learn_step(req_mode, req_is_data_packet,
               req_frame_type, req_to_ds, req_from_ds, req_addr1, req_addr2,
               req_rssi, req_channel, req_read_index));
         if (hold_next > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold <= hold_next - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold <= 0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** wlan_station_learning_table: FAILED **");
         $finish;
      end
   end

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic logic [47:0] rand_mac();
      logic [47:0] mac;
      mac = rand48();
      mac[MCAST_BIT] = 1'b0;
      return mac;
   endfunction

   // every field random, so unused fields toggle too
   function automatic req_item_type blank_req(input logic [1:0] mode);
      req_item_type it;
      it.mode = mode;
      it.is_data = 1'($urandom);
      it.ftype = 2'($urandom);
      it.to_ds = 1'($urandom);
      it.from_ds = 1'($urandom);
      it.addr1 = rand48();
      it.addr2 = rand48();
      it.rssi = 8'($urandom);
      it.channel = 8'($urandom);
      it.read_index = 8'($urandom);
      it.drain_first = 1'b0;
      return it;
   endfunction

   function automatic req_item_type observe_req(input logic [47:0] sta,
                                                input logic [47:0] ap,
                                                input bit via_to_ds);
      req_item_type it;
      it = blank_req(MODE_OBSERVE);
      it.is_data = 1'b1;
      it.ftype = FRAME_TYPE_DATA;
      it.to_ds = via_to_ds;
      it.from_ds = !via_to_ds;
      it.addr1 = via_to_ds ? ap : sta;
      it.addr2 = via_to_ds ? sta : ap;
      return it;
   endfunction

   function automatic req_item_type read_req(input logic [7:0] index);
      req_item_type it;
      it = blank_req(MODE_READ);
      it.read_index = index;
      return it;
   endfunction

   function automatic req_item_type clear_req();
      return blank_req(MODE_CLEAR);
   endfunction

   function automatic req_item_type noise_req();
      req_item_type it;
      it = blank_req(2'($urandom));
      case ($urandom_range(0, 3))
         0: begin
         end
         1: begin
            it.mode = MODE_OBSERVE;
            if ($urandom_range(0, 1)) begin
               it.is_data = 1'b0;
            end else begin
               it.ftype = 2'($urandom_range(0, 2));
               if (it.ftype == FRAME_TYPE_DATA) it.ftype = 2'd3;
            end
         end
         2: begin
            it.mode = MODE_OBSERVE;
            it.is_data = 1'b1;
            it.ftype = FRAME_TYPE_DATA;
            it.from_ds = it.to_ds;
         end
         default: begin
            // group address on the station side
            it.mode = MODE_OBSERVE;
            it.is_data = 1'b1;
            it.ftype = FRAME_TYPE_DATA;
            it.from_ds = !it.to_ds;
            if (it.to_ds) it.addr2[MCAST_BIT] = 1'b1;
            else it.addr1[MCAST_BIT] = 1'b1;
         end
      endcase
      return it;
   endfunction

   task automatic queue_req(input req_item_type it);
      request_queue.push_back(it);
      requests_queued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (request_queue.size() > 0 || req_valid || pending_results.size() > 0);
   endtask

   task automatic write_capacity(input logic [8:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      capacity_shadow = int'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_phase(input int count, input int pool_n, input bit clear_first);
      logic [47:0]  pool[$];
      req_item_type it;
      int           pick;
      repeat (pool_n) pool.push_back(rand_mac());
      if (clear_first) begin
         it = clear_req();
         it.drain_first = 1'b1;
         queue_req(it);
      end
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 62)
            it = observe_req(pool[$urandom_range(0, pool_n - 1)], rand48(),
                             1'($urandom_range(0, 1)));
         else if (pick < 77)
            it = read_req(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
                                                           $urandom_range(0, pool_n + 1)));
         else if (pick < 80)
            it = clear_req();
         else
            it = noise_req();
         if ($urandom_range(0, 39) == 0) it.drain_first = 1'b1;
         queue_req(it);
      end
   endtask

   initial begin
      req_item_type it;
      logic [47:0]  fill_pool[$];
      int           cap;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every mode and rejection, field extremes, hits and reads
      queue_req(blank_req(MODE_UNUSED));
      queue_req(clear_req());
      queue_req(read_req(8'd0));
      it = observe_req(rand_mac(), rand48(), 1'b1);
      it.is_data = 1'b0;
      queue_req(it);
      for (int t = 0; t < 4; t++) begin
         if (t != FRAME_TYPE_DATA) begin
            it = observe_req(rand_mac(), rand48(), 1'b0);
            it.ftype = 2'(t);
            queue_req(it);
         end
      end
      it = observe_req(rand_mac(), rand48(), 1'b0);
      it.to_ds = 1'b0;
      it.from_ds = 1'b0;
      queue_req(it);
      it.to_ds = 1'b1;
      it.from_ds = 1'b1;
      queue_req(it);
      queue_req(observe_req(MAC_ONES, rand48(), 1'b1));
      queue_req(observe_req(MAC_GROUP_ONLY, rand48(), 1'b0));
      it = observe_req(MAC_TOP_UNICAST, MAC_ONES, 1'b1);
      it.rssi = 8'sh80;
      it.channel = 8'hFF;
      queue_req(it);
      it = observe_req(48'h0, 48'h0, 1'b0);
      it.rssi = 8'sh7F;
      it.channel = 8'h00;
      queue_req(it);
      it = observe_req(48'h0, rand48(), 1'b1);
      it.rssi = 8'shFF;
      queue_req(it);
      // group address as access point is still learned
      queue_req(observe_req(MAC_TOP_UNICAST, MAC_GROUP_ONLY, 1'b0));
      queue_req(observe_req(rand_mac(), MAC_GROUP_ONLY, 1'b1));
      for (int r = 0; r < 4; r++) queue_req(read_req(8'(r)));
      queue_req(read_req(8'd255));
      queue_req(blank_req(MODE_UNUSED));
      queue_req(clear_req());
      queue_req(read_req(8'd0));
      queue_req(observe_req(48'h0, rand48(), 1'b1));

      // fill the whole table with a capacity above the depth
      write_capacity(9'd511);
      it = clear_req();
      it.drain_first = 1'b1;
      queue_req(it);
      for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
         fill_pool.push_back(rand_mac());
         queue_req(observe_req(fill_pool[i], rand48(), 1'($urandom_range(0, 1))));
         if (i % 8 == 7) begin
            queue_req(observe_req(fill_pool[$urandom_range(0, i)], rand48(),
                                  1'($urandom_range(0, 1))));
            queue_req(read_req(8'($urandom_range(0, (i < 255) ? i : 255))));
         end
      end
      queue_req(read_req(8'd255));
      queue_req(read_req(8'd0));

      write_capacity(9'd256);
      repeat (4) queue_req(observe_req(rand_mac(), rand48(), 1'($urandom_range(0, 1))));

      // capacity dropped below the count: old stations still hit and read
      write_capacity(9'd5);
      repeat (30) begin
         case ($urandom_range(0, 2))
            0: it = observe_req(fill_pool[$urandom_range(0, TABLE_DEPTH - 1)], rand48(),
                                1'($urandom_range(0, 1)));
            1: it = observe_req(rand_mac(), rand48(), 1'($urandom_range(0, 1)));
            default: it = read_req(8'($urandom_range(0, 255)));
         endcase
         queue_req(it);
      end

      write_capacity(9'd0);
      random_phase(20, 4, 1'b1);
      write_capacity(9'd1);
      random_phase(25, 3, 1'b1);

      while (requests_queued < REQUEST_TARGET) begin
         case ($urandom_range(0, 7))
            0: cap = 0;
            1: cap = 1;
            2: cap = $urandom_range(2, 8);
            3: cap = $urandom_range(9, 40);
            4: cap = int'(CAPACITY_RESET);
            5: cap = TABLE_DEPTH;
            6: cap = $urandom_range(TABLE_DEPTH + 1, 511);
            default: cap = $urandom_range(0, 511);
         endcase
         write_capacity(9'(cap));
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         random_phase($urandom_range(40, 90), $urandom_range(1, 24),
                      $urandom_range(0, 3) != 0);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("** wlan_station_learning_table: PASSED **");
      end else begin
         $display("** wlan_station_learning_table: FAILED **");
      end
      $finish;
   end

endmodule
